// ----- src/conv3_pkg.sv -----
// Shared types and constants for the 3x3 valid-window convolution block.
`timescale 1ns / 1ps
`default_nettype none

package conv3_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIM_W      = 11;

    // Frame geometry limits.
    localparam int MIN_DIM    = 3;
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;

    // Result field and stream packing.
    localparam int SUM_W      = 20;
    localparam int OUT_TDATA_W = 24;

    // Register reset values.
    localparam logic [DIM_W-1:0]      DIM_RESET  = 11'd7;
    localparam logic [CFG_DATA_W-1:0] KROW_RESET = 24'h010101;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_TOP    = 3'd2,
        REG_KERNEL_MID    = 3'd3,
        REG_KERNEL_BOTTOM = 3'd4
    } cfg_reg_t;

    // Per-cycle enables that the top level hands to every window cell.
    typedef struct packed {
        logic shift;     // take the neighbor's column
        logic prod_en;   // register the three products
        logic sum_en;    // register the column sum
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- src/conv2d_3x3_valid.sv -----
// Top level of the 3x3 valid-window convolution over a raster pixel stream.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one pixel per clock in raster order and, for every pixel that
// completes a full 3x3 window (row and column both at least two), returns the
// exact signed sum of window times kernel without flipping the kernel. A pixel
// passes five register stages: the line store read, the window cells, the
// products, the column sums and the output register. The first of them loads on
// the edge that takes the pixel. The sustained rate is one pixel per clock, set
// by the single read and single write that each line store does per pixel and
// by the three window cells that shift one column per pixel. A stalled output
// holds the pipeline back one stage at a time; empty stages keep taking pixels.
// The line stores start out undefined and need no clearing pass. Configuration
// must be written only while the block is idle; the block itself does not
// enforce this. Sizes outside 3..MAX_WIDTH columns and 3..1024 rows are clamped
// into that range.

module conv2d_3x3_valid import conv3_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8,
    localparam int IN_W      = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input pixel stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_W-1:0]        s_tdata,    // [PIXEL_BITS-1:0] pixel
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,    // [19:0] sum
    output logic                        m_tlast,    // frame_end
    // Configuration writes.
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW        = $clog2(MAX_WIDTH);
    localparam int WW        = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
    localparam int KEXT_W    = 3 * COEF_BITS;
    localparam int COL_SUM_W = PIXEL_BITS + COEF_BITS + 3;
    localparam int ACC_W     = COL_SUM_W + 2;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [CFG_DATA_W-1:0] krow_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_RESET;
            height_reg  <= DIM_RESET;
            krow_reg[0] <= KROW_RESET;
            krow_reg[1] <= KROW_RESET;
            krow_reg[2] <= KROW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT:  height_reg  <= cfg_wdata[DIM_W-1:0];
                REG_KERNEL_TOP:    krow_reg[0] <= cfg_wdata;
                REG_KERNEL_MID:    krow_reg[1] <= cfg_wdata;
                REG_KERNEL_BOTTOM: krow_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective frame size, clamped, minus one.
    logic [WW-1:0]    width_m1;
    logic [DIM_W-1:0] height_m1;

    always_comb begin
        if (WW'(width_reg) < WW'(MIN_DIM)) begin
            width_m1 = WW'(MIN_DIM - 1);
        end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
            width_m1 = WW'(MAX_WIDTH - 1);
        end else begin
            width_m1 = WW'(width_reg) - WW'(1);
        end
        if (height_reg < DIM_W'(MIN_DIM)) begin
            height_m1 = DIM_W'(MIN_DIM - 1);
        end else if (height_reg > DIM_W'(MAX_HEIGHT)) begin
            height_m1 = DIM_W'(MAX_HEIGHT - 1);
        end else begin
            height_m1 = height_reg - DIM_W'(1);
        end
    end

    // Kernel coefficients regrouped by column for the cells.
    logic [KEXT_W-1:0]          krow_ext [3];
    logic [2:0][COEF_BITS-1:0]  coef_col [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            krow_ext[k] = KEXT_W'(krow_reg[k]);
        end
        for (int l = 0; l < 3; l++) begin
            for (int k = 0; k < 3; k++) begin
                coef_col[l][k] = krow_ext[k][l*COEF_BITS +: COEF_BITS];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage moves when the one after it has room; stage B also moves when it holds no result.
    // ------------------------------------------------------------------
    logic a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, m_valid_reg;
    logic a_valid_next, b_valid_next, c_valid_next, d_valid_next, m_valid_next;
    logic a_out_reg, b_out_reg;
    logic a_last_reg, b_last_reg, c_last_reg, d_last_reg, m_last_reg;
    logic out_rdy, d_rdy, c_rdy, b_rdy, a_rdy;
    logic s_fire;
    cell_ctl_t cell_ctl;

    assign out_rdy  = !m_valid_reg || m_tready;
    assign d_rdy    = !d_valid_reg || out_rdy;
    assign c_rdy    = !c_valid_reg || d_rdy;
    assign b_rdy    = !b_valid_reg || !b_out_reg || c_rdy;
    assign a_rdy    = !a_valid_reg || b_rdy;
    assign s_tready = a_rdy;
    assign s_fire   = s_tvalid && a_rdy;

    assign cell_ctl.shift   = a_valid_reg && b_rdy;
    assign cell_ctl.prod_en = b_valid_reg && b_out_reg && c_rdy;
    assign cell_ctl.sum_en  = c_valid_reg && d_rdy;

    // ------------------------------------------------------------------
    // Column and row counters, updated on every input transfer.
    // ------------------------------------------------------------------
    logic [AW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             row_end, frame_last, produce;

    always_comb begin
        row_end    = WW'(col_reg) >= width_m1;
        frame_last = row_end && (DIM_W'(row_reg) >= height_m1);
        produce    = (row_reg >= ROW_W'(2)) && (AW'(2) <= col_reg);
        col_next   = col_reg;
        row_next   = row_reg;
        if (s_fire) begin
            if (row_end) begin
                col_next = '0;
                row_next = frame_last ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
    end

    // Stage valid bits.
    always_comb begin
        a_valid_next = s_fire ? 1'b1 : (b_rdy ? 1'b0 : a_valid_reg);
        b_valid_next = cell_ctl.shift ? 1'b1 : (b_rdy ? 1'b0 : b_valid_reg);
        c_valid_next = cell_ctl.prod_en ? 1'b1 : (d_rdy ? 1'b0 : c_valid_reg);
        d_valid_next = cell_ctl.sum_en ? 1'b1 : (out_rdy ? 1'b0 : d_valid_reg);
        m_valid_next = (d_valid_reg && out_rdy) ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: line store read and the captured pixel.
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] a_pix_reg;
    logic [AW-1:0]         a_addr_reg;
    logic [PIXEL_BITS-1:0] top_rd, mid_rd;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_pix_reg  <= s_tdata[PIXEL_BITS-1:0];
            a_addr_reg <= col_reg;
            a_out_reg  <= produce;
            a_last_reg <= frame_last;
        end
    end

    // The older row moves from store one to store two as the pixel leaves stage A.
    conv3_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIXEL_BITS)
    ) u_line_one (
        .aclk    (aclk),
        .wr_en   (cell_ctl.shift),
        .wr_addr (a_addr_reg),
        .wr_data (a_pix_reg),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    conv3_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (PIXEL_BITS)
    ) u_line_two (
        .aclk    (aclk),
        .wr_en   (cell_ctl.shift),
        .wr_addr (a_addr_reg),
        .wr_data (mid_rd),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (top_rd)
    );

    // ------------------------------------------------------------------
    // Stages B to D: chain of window cells, newest column in cell two.
    // ------------------------------------------------------------------
    logic [2:0][PIXEL_BITS-1:0] new_col;
    logic [2:0][PIXEL_BITS-1:0] col_bus [1:2];
    logic signed [COL_SUM_W-1:0] col_sum [3];

    assign new_col = {a_pix_reg, mid_rd, top_rd};

    for (genvar l = 0; l < 3; l++) begin : g_cell
        if (l == 0) begin : g_left
            conv3_cell #(
                .PIXEL_BITS (PIXEL_BITS),
                .COEF_BITS  (COEF_BITS)
            ) u_cell (
                .aclk     (aclk),
                .ctl      (cell_ctl),
                .col_in   (col_bus[1]),
                .coef_col (coef_col[0]),
                .col_out  (),
                .col_sum  (col_sum[0])
            );
        end else begin : g_inner
            conv3_cell #(
                .PIXEL_BITS (PIXEL_BITS),
                .COEF_BITS  (COEF_BITS)
            ) u_cell (
                .aclk     (aclk),
                .ctl      (cell_ctl),
                .col_in   ((l == 2) ? new_col : col_bus[(l == 2) ? 2 : l + 1]),
                .coef_col (coef_col[l]),
                .col_out  (col_bus[l]),
                .col_sum  (col_sum[l])
            );
        end
    end

    // Flags travel alongside the cell stages.
    always_ff @(posedge aclk) begin
        if (cell_ctl.shift) begin
            b_out_reg  <= a_out_reg;
            b_last_reg <= a_last_reg;
        end
        if (cell_ctl.prod_en) begin
            c_last_reg <= b_last_reg;
        end
        if (cell_ctl.sum_en) begin
            d_last_reg <= c_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: total of the three column sums.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] total_next;
    logic [SUM_W-1:0]        m_sum_reg;

    always_comb begin
        total_next = ACC_W'(col_sum[0]) + ACC_W'(col_sum[1]) + ACC_W'(col_sum[2]);
    end

    always_ff @(posedge aclk) begin
        if (d_valid_reg && out_rdy) begin
            m_sum_reg  <= SUM_W'(total_next);
            m_last_reg <= d_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_sum_reg);
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && frame_last |=> col_reg == '0 && row_reg == '0)
        else $error("counters did not wrap at the end of the frame");

    a_ready_means_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> a_valid_reg && b_valid_reg && b_out_reg && c_valid_reg)
        else $error("input held off while the pipeline has room");

    a_stage_b_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_out_reg && !c_rdy |=> b_valid_reg && b_out_reg)
        else $error("stalled window result was lost");

    a_stage_d_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid_reg && !out_rdy |=> d_valid_reg && $stable(d_last_reg))
        else $error("stalled column sums were lost");

endmodule

`default_nettype wire

// ----- src/conv3_line_ram.sv -----
// One line store: single write port, single registered read port.
`timescale 1ns / 1ps
`default_nettype none

module conv3_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- src/conv3_cell.sv -----
// One window column cell: three pixels, their products and the column sum.
`timescale 1ns / 1ps
`default_nettype none

module conv3_cell import conv3_pkg::*; #(
    parameter int PIXEL_BITS = 8,
    parameter int COEF_BITS  = 8,
    localparam int COL_SUM_W = PIXEL_BITS + COEF_BITS + 3
) (
    input  wire logic                              aclk,
    input  wire cell_ctl_t                         ctl,
    input  wire logic [2:0][PIXEL_BITS-1:0]        col_in,    // row 0 (oldest) at index 0
    input  wire logic [2:0][COEF_BITS-1:0]         coef_col,  // kernel row k at index k
    output logic      [2:0][PIXEL_BITS-1:0]        col_out,
    output logic signed [COL_SUM_W-1:0]            col_sum
);

    localparam int PROD_W = PIXEL_BITS + COEF_BITS + 1;

    logic [2:0][PIXEL_BITS-1:0]  pix_reg;
    logic signed [PROD_W-1:0]    prod_reg  [3];
    logic signed [PROD_W-1:0]    prod_next [3];
    logic signed [COL_SUM_W-1:0] col_sum_reg;
    logic signed [COL_SUM_W-1:0] col_sum_next;

    // Unsigned pixel times signed coefficient, one product per row.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_next[k] = PROD_W'($signed({1'b0, pix_reg[k]}) * $signed(coef_col[k]));
        end
        col_sum_next = COL_SUM_W'(prod_reg[0]) + COL_SUM_W'(prod_reg[1])
                     + COL_SUM_W'(prod_reg[2]);
    end

    // Column shift, product and sum registers.
    always_ff @(posedge aclk) begin
        if (ctl.shift) begin
            pix_reg <= col_in;
        end
        if (ctl.prod_en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= prod_next[k];
            end
        end
        if (ctl.sum_en) begin
            col_sum_reg <= col_sum_next;
        end
    end

    assign col_out = pix_reg;
    assign col_sum = col_sum_reg;

endmodule

`default_nettype wire

// ----- sim/conv2d_3x3_valid_tb.sv -----
// Testbench for conv2d_3x3_valid: pixel streams checked against a 3x3 window model.
`timescale 1ns / 1ps

module conv2d_3x3_valid_tb import conv3_pkg::*; ();

    localparam int LINE_DEPTH      = 1024;
    localparam int PIX_W           = 8;
    localparam int COEF_W          = 8;
    localparam int GAP_MAX         = 17;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PIXELS   = 550;
    localparam int RAND_WIDTH_MAX  = 12;
    localparam int RAND_HEIGHT_MAX = 8;

    localparam logic [CFG_DATA_W-1:0] KROW_ALL_MAX = 24'h7F7F7F;
    localparam logic [CFG_DATA_W-1:0] KROW_ALL_MIN = 24'h808080;
    localparam logic [DIM_W-1:0]      DIM_ALL_ONES = 11'h7FF;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic                    frame_end;
    } conv_result_t;

    typedef enum logic {
        ROW_CONFIG,
        ROW_PIXELS
    } stim_kind_t;

    // One row of the directed table: a register write, or a run of equal pixels
    // whose last one may carry a result that is known by inspection.
    typedef struct {
        stim_kind_t              kind;
        cfg_reg_t                target;
        logic [CFG_DATA_W-1:0]   value;
        int unsigned             repeats;
        bit                      known;
        logic signed [SUM_W-1:0] sum;
        logic                    frame_end;
    } stim_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata = '0;      // [7:0] pixel
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // [19:0] sum
    logic                   m_tlast;           // frame_end
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Model state: line stores, window, position counters and registers.
    logic [PIX_W-1:0]      line_one [LINE_DEPTH];
    logic [PIX_W-1:0]      line_two [LINE_DEPTH];
    logic [PIX_W-1:0]      window [9];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [DIM_W-1:0]      width_reg = DIM_RESET;
    logic [DIM_W-1:0]      height_reg = DIM_RESET;
    logic [CFG_DATA_W-1:0] kernel_reg [3] = '{KROW_RESET, KROW_RESET, KROW_RESET};

    conv_result_t pending_sums[$];
    conv_result_t oldest;
    int           error_count = 0;
    int unsigned  pixels_sent = 0;
    bit           frame_done = 1'b0;
    bit           src_steady = 1'b0;
    bit           sink_steady = 1'b0;
    bit           hold_off_req = 1'b0;

    // Three tiny frames: reset kernel, all-max kernel, all-min kernel, full-scale pixels.
    stim_row_t directed_rows [14] = '{
        '{ROW_CONFIG, REG_IMAGE_WIDTH,   24'd0,        1, 1'b0, 20'sd0,   1'b0},
        '{ROW_CONFIG, REG_IMAGE_HEIGHT,  24'd0,        1, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      8, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      1, 1'b1, 20'sd2295, 1'b1},
        '{ROW_CONFIG, REG_KERNEL_TOP,    KROW_ALL_MAX, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_CONFIG, REG_KERNEL_MID,    KROW_ALL_MAX, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_CONFIG, REG_KERNEL_BOTTOM, KROW_ALL_MAX, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      8, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      1, 1'b1, 20'sd291465, 1'b1},
        '{ROW_CONFIG, REG_KERNEL_TOP,    KROW_ALL_MIN, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_CONFIG, REG_KERNEL_MID,    KROW_ALL_MIN, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_CONFIG, REG_KERNEL_BOTTOM, KROW_ALL_MIN, 1, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      8, 1'b0, 20'sd0,   1'b0},
        '{ROW_PIXELS, REG_IMAGE_WIDTH,   24'd255,      1, 1'b1, -20'sd293760, 1'b1}
    };

    conv2d_3x3_valid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Effective frame size: register value clamped into 3..hi.
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the window model by one pixel and queue the sum it completes, if any.
    task automatic advance_window(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      slot;
        int               acc;
        bit               row_end;
        bit               last_row;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        conv_result_t     res;
        w = clamp_dim(width_reg, LINE_DEPTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        slot = col_pos % LINE_DEPTH;
        top = line_two[slot];
        mid = line_one[slot];
        line_two[slot] = mid;
        line_one[slot] = px;
        for (int k = 0; k < 3; k++) begin
            window[k*3]     = window[k*3 + 1];
            window[k*3 + 1] = window[k*3 + 2];
        end
        window[2] = top;
        window[5] = mid;
        window[8] = px;
        row_end  = (col_pos >= w - 1);
        last_row = row_end && (row_pos >= h - 1);
        if (row_pos >= 2 && col_pos >= 2) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
                for (int l = 0; l < 3; l++) begin
                    acc += int'(window[k*3 + l]) * int'($signed(kernel_reg[k][COEF_W*l +: COEF_W]));
                end
            end
            res.sum = acc[SUM_W-1:0];
            res.frame_end = last_row;
            pending_sums.push_back(res);
        end
        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
            if (last_row) frame_done = 1'b1;
        end else begin
            col_pos++;
        end
    endtask

    // Offer one pixel after a random gap and model it once the transfer happens.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int unsigned gap;
        gap = src_steady ? 0 : $urandom_range(0, GAP_MAX);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        advance_window(px);
        pixels_sent++;
    endtask

    // Stop offering pixels, wait for every queued sum, then let the pipeline settle.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_sums.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:   width_reg = val[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  height_reg = val[DIM_W-1:0];
            REG_KERNEL_TOP:    kernel_reg[0] = val;
            REG_KERNEL_MID:    kernel_reg[1] = val;
            REG_KERNEL_BOTTOM: kernel_reg[2] = val;
            default: ;
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_kernel_row();
        case ($urandom_range(0, 5))
            0: return KROW_ALL_MAX;
            1: return KROW_ALL_MIN;
            2: return '0;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // Mostly legal sizes, now and then one that the block has to clamp up.
    function automatic logic [CFG_DATA_W-1:0] random_dim(input int unsigned hi);
        if ($urandom_range(0, 9) == 0) return CFG_DATA_W'($urandom_range(0, MIN_DIM - 1));
        return CFG_DATA_W'($urandom_range(MIN_DIM, hi));
    endfunction

    task automatic write_all_kernels();
        write_reg(REG_KERNEL_TOP, random_kernel_row());
        write_reg(REG_KERNEL_MID, random_kernel_row());
        write_reg(REG_KERNEL_BOTTOM, random_kernel_row());
    endtask

    // Change a size and one kernel row while the counters sit mid-frame.
    task automatic retune_mid_frame();
        if ($urandom_range(0, 1) == 0) write_reg(REG_IMAGE_WIDTH, random_dim(RAND_WIDTH_MAX));
        else write_reg(REG_IMAGE_HEIGHT, random_dim(RAND_HEIGHT_MAX));
        case ($urandom_range(0, 2))
            0: write_reg(REG_KERNEL_TOP, random_kernel_row());
            1: write_reg(REG_KERNEL_MID, random_kernel_row());
            default: write_reg(REG_KERNEL_BOTTOM, random_kernel_row());
        endcase
    endtask

    // Feed random pixels until the model closes the frame.
    task automatic stream_frame(input int unsigned retune_at);
        int unsigned n;
        n = 0;
        while (!frame_done) begin
            if (retune_at != 0 && n == retune_at) retune_mid_frame();
            send_pixel(PIX_W'($urandom_range(0, 255)));
            n++;
        end
    endtask

    // Compare every result transfer with the oldest queued sum.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                $error("sum: expected none, actual %0d", $signed(m_tdata[SUM_W-1:0]));
                error_count++;
            end else begin
                oldest = pending_sums.pop_front();
                if (m_tdata[SUM_W-1:0] !== oldest.sum) begin
                    $error("sum: expected %0d, actual %0d", oldest.sum,
                           $signed(m_tdata[SUM_W-1:0]));
                    error_count++;
                end
                if (m_tlast !== oldest.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", oldest.frame_end, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Result side: random stalls per transfer, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned pause;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            pause = sink_steady ? 0 : $urandom_range(0, GAP_MAX);
            if (pause != 0) begin
                m_tready = 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #10_000_000;
        $display("conv2d_3x3_valid_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned n;
        int unsigned base;
        int unsigned area;
        int unsigned retune_at;
        foreach (line_one[i]) begin
            line_one[i] = '0;
            line_two[i] = '0;
        end
        foreach (window[i]) window[i] = '0;
        col_pos = 0;
        row_pos = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table; rows with a known sum override the model's value.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                write_reg(directed_rows[i].target, directed_rows[i].value);
            end else begin
                repeat (directed_rows[i].repeats) send_pixel(directed_rows[i].value[PIX_W-1:0]);
                if (directed_rows[i].known && pending_sums.size() != 0) begin
                    pending_sums[pending_sums.size() - 1].sum = directed_rows[i].sum;
                    pending_sums[pending_sums.size() - 1].frame_end = directed_rows[i].frame_end;
                end
            end
        end

        // Frame at the largest random size, which also fills every line store
        // column that later frames read. The result side holds off from the
        // start of the first full row while the source offers its next pixels back to back.
        frame_done = 1'b0;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(RAND_WIDTH_MAX));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(RAND_HEIGHT_MAX));
        write_all_kernels();
        n = 0;
        while (!frame_done) begin
            if (n == 2 * RAND_WIDTH_MAX) begin
                hold_off_req = 1'b1;
                src_steady = 1'b1;
            end
            if (n == 2 * RAND_WIDTH_MAX + 40) src_steady = 1'b0;
            send_pixel(PIX_W'($urandom_range(0, 255)));
            n++;
        end

        // Tallest frame setting, cut short by lowering the height a few rows in.
        frame_done = 1'b0;
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(MIN_DIM));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(DIM_ALL_ONES));
        repeat (5 * MIN_DIM) send_pixel(PIX_W'($urandom_range(0, 255)));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(MIN_DIM));
        stream_frame(0);

        // Random small frames, some with sizes or kernels changed mid-frame.
        base = pixels_sent;
        while (pixels_sent - base < RANDOM_PIXELS) begin
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            frame_done = 1'b0;
            write_reg(REG_IMAGE_WIDTH, random_dim(RAND_WIDTH_MAX));
            write_reg(REG_IMAGE_HEIGHT, random_dim(RAND_HEIGHT_MAX));
            write_all_kernels();
            area = clamp_dim(width_reg, LINE_DEPTH) * clamp_dim(height_reg, MAX_HEIGHT);
            retune_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area - 1) : 0;
            stream_frame(retune_at);
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;

        drain_results();
        if (error_count == 0 && pending_sums.size() == 0) begin
            $display("conv2d_3x3_valid_tb: done, clean");
        end else begin
            $display("conv2d_3x3_valid_tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/conv3_pkg.sv
src/conv3_line_ram.sv
src/conv3_cell.sv
src/conv2d_3x3_valid.sv
sim/conv2d_3x3_valid_tb.sv
